// ===== hw/rtl/slts_pkg.sv =====
package slts_pkg;

  localparam int unsigned MAX_PIX_W  = 10;
  localparam int unsigned VIEW_W     = 9;
  localparam int unsigned TOTAL_W    = 11;
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [MAX_PIX_W-1:0] MAX_PIX_RESET = 10'd320;
  localparam logic [VIEW_W-1:0]    VIEW_RESET    = 9'd320;

  localparam logic [9:0]         DISPLAY_OFFSET = 10'h080;
  localparam logic [9:0]         BUFFER_ADJUST  = 10'h060;
  localparam logic [TOTAL_W-1:0] TOTAL_SAT      = 11'h7FF;

  localparam logic CMD_SPRITE = 1'b0;
  localparam logic CMD_EOL    = 1'b1;

  localparam logic REG_MAX_PIX = 1'b0;
  localparam logic REG_VIEW_W  = 1'b1;

  typedef struct packed {
    logic        cmd;
    logic [8:0]  sprite_xpos;
    logic [3:0]  sprite_size;
    logic [15:0] sprite_attr;
    logic [4:0]  sprite_row;
  } in_item_t;

  typedef struct packed {
    logic [9:0]  buffer_x;
    logic [6:0]  tile_attr;
    logic [1:0]  flip_bits;
    logic [10:0] name_base;
    logic [9:0]  lut_index;
    logic [2:0]  pattern_row;
    logic        last_tile;
  } out_item_t;

  typedef struct packed {
    logic accept;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic has_tiles;
    logic last_col;
    logic out_free;
  } dp_status_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EMIT = 2'b10
  } state_t;

endpackage

// ===== hw/rtl/slts_regs.sv =====
module slts_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [slts_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [slts_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [slts_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready,
  output logic [slts_pkg::MAX_PIX_W-1:0]  max_pix,
  output logic [slts_pkg::VIEW_W-1:0]     view_w
);
  import slts_pkg::*;

  logic [MAX_PIX_W-1:0] max_pix_r, max_pix_nxt;
  logic [VIEW_W-1:0]    view_w_r, view_w_nxt;
  logic                 wr_en;
  logic                 sel;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign sel    = paddr[2];

  always_comb begin
    max_pix_nxt = max_pix_r;
    view_w_nxt  = view_w_r;
    if (wr_en) begin
      case (sel)
        REG_MAX_PIX: max_pix_nxt = pwdata[MAX_PIX_W-1:0];
        REG_VIEW_W:  view_w_nxt  = pwdata[VIEW_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_pix_r <= MAX_PIX_RESET;
      view_w_r  <= VIEW_RESET;
    end else begin
      max_pix_r <= max_pix_nxt;
      view_w_r  <= view_w_nxt;
    end
  end

  always_comb begin
    case (sel)
      REG_MAX_PIX: prdata = {{(CFG_DATA_W-MAX_PIX_W){1'b0}}, max_pix_r};
      REG_VIEW_W:  prdata = {{(CFG_DATA_W-VIEW_W){1'b0}}, view_w_r};
      default:     prdata = '0;
    endcase
  end

  assign max_pix = max_pix_r;
  assign view_w  = view_w_r;

endmodule

// ===== hw/rtl/slts_ctrl.sv =====
module slts_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  slts_pkg::dp_status_t   status,
  output slts_pkg::ctrl_cmd_t    cmd
);
  import slts_pkg::*;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt    = state_r;
    cmd.accept   = 1'b0;
    cmd.load_out = 1'b0;
    in_stall     = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
        if (in_valid && status.has_tiles) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        cmd.load_out = status.out_free;
        if (status.out_free && status.last_col) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== hw/rtl/slts_dp.sv =====
module slts_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  slts_pkg::in_item_t            in_data,
  input  slts_pkg::ctrl_cmd_t           cmd,
  output slts_pkg::dp_status_t          status,
  input  logic [slts_pkg::MAX_PIX_W-1:0] max_pix,
  input  logic [slts_pkg::VIEW_W-1:0]    view_w,
  output logic                          out_valid,
  input  logic                          out_stall,
  output slts_pkg::out_item_t           out_data
);
  import slts_pkg::*;

  // line state
  logic               ovf_r, ovf_nxt;
  logic [TOTAL_W-1:0] total_r, total_nxt;
  logic               mask_r, mask_nxt;
  logic               stop_r, stop_nxt;

  // sprite held for emission
  logic [9:0]  bx_base_r;
  logic [6:0]  tattr_r;
  logic [1:0]  flips_r;
  logic [10:0] name_r;
  logic [9:0]  lut_r;
  logic [2:0]  prow_r;
  logic [2:0]  tiles_r;
  logic [1:0]  col_r;

  out_item_t out_r;
  logic      out_valid_r, out_valid_nxt;

  logic [5:0]          width_px;
  logic [TOTAL_W:0]    sum;
  logic [TOTAL_W-1:0]  total_sat;
  logic                mask_new;
  logic [9:0]          right_edge;
  logic [9:0]          view_end;
  logic                visible;
  logic signed [12:0]  eff_w;
  logic [2:0]          tiles;
  logic                stop_hit;

  assign width_px   = {1'b0, in_data.sprite_size[3:2], 3'b000} + 6'd8;
  assign sum        = {1'b0, total_r} + {6'b0, width_px};
  assign total_sat  = sum[TOTAL_W] ? TOTAL_SAT : sum[TOTAL_W-1:0];
  assign mask_new   = mask_r || ((in_data.sprite_xpos == 9'd0) && ovf_r);
  assign right_edge = {1'b0, in_data.sprite_xpos} + {4'b0, width_px};
  assign view_end   = {1'b0, view_w} + DISPLAY_OFFSET;
  assign visible    = (right_edge > DISPLAY_OFFSET) &&
                      ({1'b0, in_data.sprite_xpos} < view_end);
  assign stop_hit   = total_sat >= {1'b0, max_pix};

  always_comb begin
    if (total_sat > {1'b0, max_pix}) begin
      eff_w = $signed({7'b0, width_px}) - ($signed({2'b0, total_sat})
              - $signed({3'b0, max_pix}));
    end else begin
      eff_w = $signed({7'b0, width_px});
    end
    if (eff_w[12]) begin
      tiles = 3'd0;
    end else begin
      tiles = eff_w[5:3];
    end
  end

  assign status.has_tiles = (in_data.cmd == CMD_SPRITE) && !stop_r && visible &&
                            !mask_new && (tiles != 3'd0);
  assign status.last_col  = ({1'b0, col_r} == (tiles_r - 3'd1));
  assign status.out_free  = !out_valid_r || !out_stall;

  always_comb begin
    ovf_nxt   = ovf_r;
    total_nxt = total_r;
    mask_nxt  = mask_r;
    stop_nxt  = stop_r;
    if (cmd.accept) begin
      if (in_data.cmd == CMD_EOL) begin
        if (!stop_r) begin
          ovf_nxt = 1'b0;
        end
        total_nxt = '0;
        mask_nxt  = 1'b0;
        stop_nxt  = 1'b0;
      end else if (!stop_r) begin
        mask_nxt  = mask_new;
        total_nxt = total_sat;
        if (stop_hit) begin
          ovf_nxt  = total_sat >= {2'b0, view_w};
          stop_nxt = 1'b1;
        end else if (in_data.sprite_xpos != 9'd0) begin
          ovf_nxt = 1'b1;
        end
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovf_r       <= 1'b0;
      total_r     <= '0;
      mask_r      <= 1'b0;
      stop_r      <= 1'b0;
      out_valid_r <= 1'b0;
      col_r       <= '0;
    end else begin
      ovf_r       <= ovf_nxt;
      total_r     <= total_nxt;
      mask_r      <= mask_nxt;
      stop_r      <= stop_nxt;
      out_valid_r <= out_valid_nxt;
      if (cmd.accept) begin
        col_r <= '0;
      end else if (cmd.load_out) begin
        col_r <= col_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      bx_base_r <= {1'b0, in_data.sprite_xpos} - BUFFER_ADJUST;
      tattr_r   <= {in_data.sprite_attr[15:13], 4'b0000};
      flips_r   <= in_data.sprite_attr[12:11];
      name_r    <= in_data.sprite_attr[10:0];
      lut_r     <= {in_data.sprite_attr[12:11], in_data.sprite_size,
                    in_data.sprite_row[4:3], 2'b00};
      prow_r    <= in_data.sprite_row[2:0];
      tiles_r   <= tiles;
    end
    if (cmd.load_out) begin
      out_r.buffer_x    <= bx_base_r + {5'b0, col_r, 3'b000};
      out_r.tile_attr   <= tattr_r;
      out_r.flip_bits   <= flips_r;
      out_r.name_base   <= name_r;
      out_r.lut_index   <= lut_r + {8'b0, col_r};
      out_r.pattern_row <= prow_r;
      out_r.last_tile   <= status.last_col;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== hw/rtl/sprite_line_tile_scheduler.sv =====
// channel   direction  handshake           payload
// in_       input      in_valid/in_stall    in_item_t  (sprite entry or end of line)
// out_      output     out_valid/out_stall  out_item_t (one tile draw command)
// cfg       input      psel/penable/pwrite  max_line_pixels @0, viewport_width @4
//
// an input transaction is taken while the sequencer is idle; a sprite then issues its 1 to 4
// tile commands from the emit sequencer, one per cycle while out_stall is low
// the output register lets the next input be taken while the last command waits
// out_stall holds the emit sequencer and therefore in_stall
// rst_n is synchronous; registers return to 320/320 and line state to zero
module sprite_line_tile_scheduler (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  slts_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output slts_pkg::out_item_t             out_data,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [slts_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [slts_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [slts_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready
);
  import slts_pkg::*;

  logic [MAX_PIX_W-1:0] max_pix;
  logic [VIEW_W-1:0]    view_w;
  ctrl_cmd_t            cmd;
  dp_status_t           status;

  slts_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .max_pix (max_pix),
    .view_w  (view_w)
  );

  slts_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  slts_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .max_pix   (max_pix),
    .view_w    (view_w),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
